@@ sv/risq_pkg.sv @@
// Package with the sizes, item kinds and state types of the range square-root store.
`default_nettype none
package risq_pkg;
	localparam int MAX_ELEMENTS = 65536;
	localparam int BLOCK_SIZE = 256;
	localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int EW = $clog2(MAX_ELEMENTS);
	localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int OW = $clog2(BLOCK_SIZE);
	localparam int TW = 31 + OW + 1;
	localparam int SW = 47;
	localparam int QDEPTH = 4;
	localparam int QW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_SQRT = 2'd1,
		KIND_SUM  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SQRT,
		OP_SUM,
		OP_FIXED
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [30:0] value;
		logic        err;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_RD,
		ST_LOAD_WR,
		ST_BLK,
		ST_RD,
		ST_WAIT,
		ST_ROOT,
		ST_NEXT,
		ST_BSUM,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ sv/risq_front.sv @@
// Front end: classifies each request, clips its range and queues a command for each request it keeps.
`default_nettype none
module risq_front import risq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] left_index,
	input  wire logic [15:0] right_index,
	input  wire logic [30:0] load_value,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_take
);
	cmd_t         q_q [QDEPTH];
	logic [QW:0]  cnt_q;
	logic [QW-1:0] wp_q, rp_q;
	cmd_t         c;
	logic         keep;
	logic [16:0]  hi_c;
	logic         wr, rd;

	always_comb begin
		hi_c = ({1'b0, right_index} > 17'(MAX_ELEMENTS - 1)) ? 17'(MAX_ELEMENTS - 1)
			: {1'b0, right_index};
		c = '0;
		c.lo = left_index;
		c.hi = hi_c[15:0];
		c.value = load_value;
		keep = 1'b0;
		unique case (kind_t'(kind))
			KIND_LOAD: begin
				c.op = OP_LOAD;
				keep = {1'b0, left_index} < 17'(MAX_ELEMENTS);
			end
			KIND_SQRT: begin
				c.op = OP_SQRT;
				keep = {1'b0, left_index} <= hi_c;
			end
			KIND_SUM: begin
				keep = 1'b1;
				if ({1'b0, left_index} <= hi_c) begin
					c.op = OP_SUM;
				end else begin
					c.op = OP_FIXED;
					c.err = left_index > right_index;
				end
			end
			default: keep = 1'b0;
		endcase
	end

	assign full = cnt_q == (QW+1)'(QDEPTH);
	assign wr = push && !full && keep;
	assign rd = cmd_take && cmd_valid;
	assign cmd_valid = cnt_q != '0;
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QW+1)'(wr) - (QW+1)'(rd);
		end
	end
endmodule
`default_nettype wire

@@ sv/risq_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
`default_nettype none
module risq_isqrt import risq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [30:0] v,
	output logic             done,
	output logic [30:0] root
);
	logic [31:0] rem_q, root_q, bit_q;
	logic        busy_q;
	logic [31:0] t;

	assign t = root_q + bit_q;
	assign root = root_q[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			rem_q <= '0;
			root_q <= '0;
			bit_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rem_q <= {1'b0, v};
				root_q <= '0;
				bit_q <= 32'h4000_0000;
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					if (rem_q >= t) begin
						rem_q <= rem_q - t;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/risq_back.sv @@
// Back end: element memory, block sums and flags, and the sequencer that runs commands.
`default_nettype none
module risq_back import risq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             cmd_take,
	output logic             res_valid,
	output logic [SW-1:0]    res_sum,
	output logic             res_err,
	input  wire logic        res_take
);
	logic [30:0]   mem [MAX_ELEMENTS];
	logic [30:0]   rd_q;
	logic [TW-1:0] tot_q [NUM_BLOCKS];
	logic [TW-1:0] tot_rd_q;
	logic [NUM_BLOCKS-1:0] bval_q, set_q;

	state_t        st_q, st_d;
	cmd_t          c_q;
	logic [BW-1:0] b_q, bl_q, br_q;
	logic [EW-1:0] i_q, up_q;
	logic [TW-1:0] bacc_q;
	logic          peak_q;
	logic [SW-1:0] acc_q;
	logic          rv_q, err_q;

	logic          mem_rd, mem_wr;
	logic [EW-1:0] mem_wa;
	logic [30:0]   mem_wd;
	logic          tot_wr;
	logic [TW-1:0] tot_wd;
	logic          sq_start, sq_done;
	logic [30:0]   sq_root;
	logic [TW-1:0] tot_b;
	logic          edge_b;
	logic [EW-1:0] bs, be, lo_b, up_b;
	logic [EW:0]   be_w;
	logic [30:0]   newv;

	risq_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .v(rd_q), .done(sq_done), .root(sq_root)
	);

	assign tot_b = bval_q[b_q] ? tot_rd_q : '0;
	assign edge_b = (b_q == bl_q) || (b_q == br_q);
	assign bs = EW'({b_q, OW'(0)});
	assign be_w = (EW+1)'(bs) + (EW+1)'(BLOCK_SIZE - 1);
	assign be = (be_w > (EW+1)'(MAX_ELEMENTS - 1)) ? EW'(MAX_ELEMENTS - 1) : be_w[EW-1:0];
	assign lo_b = (c_q.op == OP_SQRT) ? bs
		: ((bs > c_q.lo[EW-1:0]) ? bs : c_q.lo[EW-1:0]);
	assign up_b = (c_q.op == OP_SQRT) ? be
		: ((be < c_q.hi[EW-1:0]) ? be : c_q.hi[EW-1:0]);
	assign newv = sq_root;
	assign res_valid = rv_q;
	assign res_sum = acc_q;
	assign res_err = err_q;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_rd) begin
			rd_q <= mem[i_q];
		end
		if (tot_wr) begin
			tot_q[b_q] <= tot_wd;
		end
		tot_rd_q <= tot_q[b_q];
	end

	always_comb begin
		st_d = st_q;
		cmd_take = 1'b0;
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		mem_wa = i_q;
		mem_wd = sq_root;
		tot_wr = 1'b0;
		tot_wd = bacc_q;
		sq_start = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				mem_wr = 1'b1;
				mem_wd = '0;
				if (i_q == EW'(MAX_ELEMENTS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid && !rv_q) begin
					cmd_take = 1'b1;
					unique case (cmd.op)
						OP_LOAD: st_d = ST_LOAD_RD;
						OP_FIXED: st_d = ST_DONE;
						default: st_d = ST_BLK;
					endcase
				end
			end
			ST_LOAD_RD: begin
				mem_rd = 1'b1;
				st_d = ST_LOAD_WR;
			end
			ST_LOAD_WR: begin
				mem_wr = 1'b1;
				mem_wd = c_q.value;
				tot_wr = 1'b1;
				tot_wd = tot_b - TW'(bval_q[b_q] ? rd_q : 31'd0) + TW'(c_q.value);
				st_d = ST_IDLE;
			end
			ST_BLK: begin
				if (!edge_b && (c_q.op == OP_SUM || set_q[b_q])) begin
					st_d = ST_BSUM;
				end else begin
					st_d = ST_RD;
				end
			end
			ST_RD: begin
				mem_rd = 1'b1;
				st_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (c_q.op == OP_SQRT) begin
					sq_start = (i_q >= c_q.lo[EW-1:0]) && (i_q <= c_q.hi[EW-1:0]);
					st_d = sq_start ? ST_ROOT : ST_NEXT;
				end else begin
					st_d = ST_NEXT;
				end
			end
			ST_ROOT: begin
				if (sq_done) begin
					mem_wr = 1'b1;
					st_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (i_q == up_q) begin
					st_d = ST_BSUM;
				end else begin
					st_d = ST_RD;
				end
			end
			ST_BSUM: begin
				if (c_q.op != OP_SUM && (edge_b || !set_q[b_q])) begin
					tot_wr = 1'b1;
					tot_wd = bacc_q;
				end
				st_d = (b_q == br_q) ? ((c_q.op == OP_SUM) ? ST_DONE : ST_IDLE) : ST_BLK;
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			bval_q <= '0;
			set_q <= '0;
			rv_q <= 1'b0;
			err_q <= 1'b0;
			acc_q <= '0;
			c_q <= '0;
			b_q <= '0;
			bl_q <= '0;
			br_q <= '0;
			i_q <= '0;
			up_q <= '0;
			bacc_q <= '0;
			peak_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (res_take && rv_q) begin
				rv_q <= 1'b0;
			end
			unique case (st_q)
				ST_CLEAR: begin
					i_q <= i_q + 1'b1;
				end
				ST_IDLE: begin
					if (cmd_take) begin
						c_q <= cmd;
						i_q <= cmd.lo[EW-1:0];
						bl_q <= BW'(cmd.lo[EW-1:0] >> OW);
						br_q <= BW'(cmd.hi[EW-1:0] >> OW);
						b_q <= BW'(cmd.lo[EW-1:0] >> OW);
						acc_q <= '0;
						err_q <= cmd.err;
					end
				end
				ST_LOAD_WR: begin
					bval_q[b_q] <= 1'b1;
					set_q[b_q] <= 1'b0;
				end
				ST_BLK: begin
					i_q <= lo_b;
					up_q <= up_b;
					bacc_q <= '0;
					peak_q <= 1'b0;
				end
				ST_WAIT: begin
					if (c_q.op == OP_SUM) begin
						acc_q <= acc_q + SW'(rd_q);
					end else if (st_d == ST_NEXT) begin
						bacc_q <= bacc_q + TW'(rd_q);
						peak_q <= peak_q | (rd_q > 31'd1);
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						bacc_q <= bacc_q + TW'(newv);
						peak_q <= peak_q | (newv > 31'd1);
					end
				end
				ST_NEXT: begin
					if (i_q != up_q) begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_BSUM: begin
					if (c_q.op == OP_SUM) begin
						if (!edge_b) begin
							acc_q <= acc_q + SW'(tot_b);
						end
					end else if (edge_b || !set_q[b_q]) begin
						bval_q[b_q] <= 1'b1;
						set_q[b_q] <= !peak_q;
					end
					b_q <= b_q + 1'b1;
				end
				ST_DONE: rv_q <= 1'b1;
				default: ;
			endcase
			if (st_q == ST_LOAD_RD) begin
				b_q <= BW'(c_q.lo[EW-1:0] >> OW);
			end
		end
	end
endmodule
`default_nettype wire

@@ sv/range_isqrt_range_sum_store.sv @@
// Top level of the range square-root / range-sum store.
// Sequence: a load passes ST_LOAD_RD and ST_LOAD_WR in the back end; a range request walks
// each element of an edge block through ST_RD, ST_WAIT, ST_NEXT (and ST_ROOT for a root),
// and a summed or settled interior block only through ST_BLK and ST_BSUM.
// Throughput: one request in the back end at a time; a four-entry queue buffers the front.
// Reset clears control state and flags at once; ST_CLEAR then zeroes every element.
`default_nettype none
module range_isqrt_range_sum_store import risq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [15:0] left_index,
	input  wire logic [15:0] right_index,
	input  wire logic [30:0] load_value,
	output logic             empty,
	input  wire logic        pop,
	output logic [46:0]      range_sum,
	output logic             range_error
);
	logic cmd_valid, cmd_take, res_valid;
	cmd_t cmd;

	risq_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.left_index(left_index), .right_index(right_index), .load_value(load_value),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	risq_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take),
		.res_valid(res_valid), .res_sum(range_sum), .res_err(range_error), .res_take(pop)
	);

	assign empty = !res_valid;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && range_error) |-> (range_sum == '0))
		else $error("Error result carries a nonzero sum.");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(range_sum)))
		else $error("Waiting result changed.");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("Command taken from an empty queue.");
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the range square-root / range-sum store.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import risq_pkg::*;

	typedef struct {
		logic [46:0] sum;
		logic        err;
	} sum_result_t;

	localparam int LOW_END  = 3 * BLOCK_SIZE - 1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  kind = KIND_NONE;
	logic [15:0] left_index = '0;
	logic [15:0] right_index = '0;
	logic [30:0] load_value = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [46:0] range_sum;
	logic        range_error;

	logic [30:0]     elem_mirror [MAX_ELEMENTS];
	longint unsigned block_sum_mirror [NUM_BLOCKS];
	bit              block_flat_mirror [NUM_BLOCKS];
	sum_result_t     pending_sums [$];

	int fails = 0;
	int requests_sent = 0;
	int sums_checked = 0;
	int burst_left = 0;
	int hold_cycles = 0;
	bit steady_pop = 1'b0;

	range_isqrt_range_sum_store dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.left_index(left_index), .right_index(right_index), .load_value(load_value),
		.empty(empty), .pop(pop), .range_sum(range_sum), .range_error(range_error)
	);

	always #5 clk = ~clk;

	function automatic logic [30:0] floor_root(logic [30:0] v);
		int unsigned rem, root, b;
		rem = v;
		root = 0;
		b = 32'h4000_0000;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root[30:0];
	endfunction

	function automatic void refresh_mirror_block(int b);
		longint unsigned acc;
		bit flat;
		int last;
		acc = 0;
		flat = 1'b1;
		last = (b + 1) * BLOCK_SIZE - 1;
		if (last > MAX_ELEMENTS - 1) last = MAX_ELEMENTS - 1;
		for (int i = b * BLOCK_SIZE; i <= last; i++) begin
			acc += elem_mirror[i];
			if (elem_mirror[i] > 1) flat = 1'b0;
		end
		block_sum_mirror[b] = acc;
		block_flat_mirror[b] = flat;
	endfunction

	function automatic void predict_request(logic [1:0] k, int l, int r, logic [30:0] v);
		int hi, bl, br, lo, up, b;
		longint unsigned acc;
		sum_result_t res;
		if (k == KIND_LOAD) begin
			b = l / BLOCK_SIZE;
			block_sum_mirror[b] = block_sum_mirror[b] - elem_mirror[l] + v;
			elem_mirror[l] = v;
			block_flat_mirror[b] = 1'b0;
			return;
		end
		if (k == KIND_NONE) return;
		if (l > r) begin
			if (k == KIND_SUM) begin
				res.sum = '0;
				res.err = 1'b1;
				pending_sums.push_back(res);
			end
			return;
		end
		hi = (r > MAX_ELEMENTS - 1) ? MAX_ELEMENTS - 1 : r;
		bl = l / BLOCK_SIZE;
		br = hi / BLOCK_SIZE;
		acc = 0;
		for (b = bl; b <= br; b++) begin
			lo = (b * BLOCK_SIZE > l) ? b * BLOCK_SIZE : l;
			up = ((b + 1) * BLOCK_SIZE - 1 < hi) ? (b + 1) * BLOCK_SIZE - 1 : hi;
			if (k == KIND_SQRT) begin
				if (b != bl && b != br && block_flat_mirror[b]) continue;
				for (int i = lo; i <= up; i++) elem_mirror[i] = floor_root(elem_mirror[i]);
				refresh_mirror_block(b);
			end else if (b != bl && b != br) begin
				acc += block_sum_mirror[b];
			end else begin
				for (int i = lo; i <= up; i++) acc += elem_mirror[i];
			end
		end
		if (k == KIND_SUM) begin
			res.sum = acc[46:0];
			res.err = 1'b0;
			pending_sums.push_back(res);
		end
	endfunction

	task automatic report_mismatch(string what);
		$display("tb: mismatch at %0t: %s", $time, what);
		fails++;
	endtask

	task automatic send_request(logic [1:0] k, int l, int r, logic [30:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		push <= 1'b1;
		kind <= k;
		left_index <= l[15:0];
		right_index <= r[15:0];
		load_value <= v;
		do @(posedge clk); while (full);
		predict_request(k, l, r, v);
		burst_left--;
		requests_sent++;
	endtask

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (pending_sums.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				if (range_sum !== pending_sums[0].sum)
					report_mismatch($sformatf("range_sum %0d, expected %0d",
						range_sum, pending_sums[0].sum));
				if (range_error !== pending_sums[0].err)
					report_mismatch($sformatf("range_error %0b, expected %0b",
						range_error, pending_sums[0].err));
				void'(pending_sums.pop_front());
				sums_checked++;
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			pop <= 1'b0;
		end else begin
			pop <= steady_pop || ($urandom_range(0, 3) != 0);
		end
	end

	function automatic logic [30:0] random_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 2000);
			2: return 31'h7FFF_FFFF - $urandom_range(0, 15);
			default: return $urandom & 31'h7FFF_FFFF;
		endcase
	endfunction

	function automatic int loaded_index();
		return $urandom_range(0, LOW_END);
	endfunction

	task automatic send_range(logic [1:0] k);
		int a, b;
		a = loaded_index();
		if ($urandom_range(0, 2) == 0)
			b = a + $urandom_range(0, 8);
		else
			b = loaded_index();
		if (b > LOW_END) b = LOW_END;
		if (a > b) begin
			a = a ^ b; b = a ^ b; a = a ^ b;
		end
		send_request(k, a, b, $urandom & 31'h7FFF_FFFF);
	endtask

	task automatic test_preload();
		for (int i = 0; i <= LOW_END; i++) send_request(KIND_LOAD, i, 0, random_value());
	endtask

	task automatic test_directed();
		send_request(KIND_LOAD, 0, 0, 31'h7FFF_FFFF);
		send_request(KIND_LOAD, MAX_ELEMENTS - 1, 16'hFFFF, 31'h7FFF_FFFF);
		send_request(KIND_LOAD, 1, 0, '0);
		send_request(KIND_SUM, 0, LOW_END, '0);
		send_request(KIND_SUM, 0, 0, '0);
		send_request(KIND_SUM, MAX_ELEMENTS - 1, MAX_ELEMENTS - 1, '0);
		send_request(KIND_SUM, 16'hFFFF, 0, '0);
		send_request(KIND_SQRT, 16'hFFFF, 0, '0);
		send_request(KIND_SUM, 5, 4, '0);
		send_request(KIND_NONE, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF);
		send_request(KIND_NONE, 0, 0, '0);
		send_request(KIND_SQRT, 3, BLOCK_SIZE + 7, '0);
		send_request(KIND_SUM, 0, BLOCK_SIZE * 2, '0);
		send_request(KIND_SUM, LOW_END - 3, LOW_END, '0);
	endtask

	task automatic test_settle();
		repeat (6) send_request(KIND_SQRT, 0, LOW_END, '0);
		send_request(KIND_SUM, 0, LOW_END, '0);
		send_request(KIND_LOAD, BLOCK_SIZE + 9, 0, 31'h7FFF_FFFF);
		send_request(KIND_SQRT, 0, LOW_END, '0);
		send_request(KIND_SUM, 0, LOW_END, '0);
		send_request(KIND_SUM, BLOCK_SIZE, 2 * BLOCK_SIZE - 1, '0);
		for (int i = 0; i < 4; i++)
			send_request(KIND_LOAD, $urandom_range(0, LOW_END), 0, random_value());
	endtask

	task automatic test_backpressure();
		hold_cycles = 40000;
		repeat (16) send_range(KIND_SUM);
	endtask

	task automatic test_random();
		steady_pop = 1'b1;
		repeat (10) send_range($urandom_range(0, 1) ? KIND_SUM : KIND_SQRT);
		steady_pop = 1'b0;
		repeat (40) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6:
					send_request(KIND_LOAD, loaded_index(),
						$urandom & 16'hFFFF, random_value());
				7, 8, 9, 10, 11, 12, 13: send_range(KIND_SUM);
				14, 15, 16, 17: send_range(KIND_SQRT);
				18: send_request($urandom_range(0, 1) ? KIND_SUM : KIND_SQRT,
					$urandom_range(1, 16'hFFFF), 0, $urandom & 31'h7FFF_FFFF);
				default: send_request(KIND_NONE, $urandom & 16'hFFFF, $urandom & 16'hFFFF,
					$urandom & 31'h7FFF_FFFF);
			endcase
		end
	endtask

	initial begin
		for (int i = 0; i < MAX_ELEMENTS; i++) elem_mirror[i] = '0;
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			block_sum_mirror[b] = 0;
			block_flat_mirror[b] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_preload();
		test_directed();
		test_settle();
		test_backpressure();
		test_random();
		push <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (12000) @(posedge clk);
		$display("tb: %0d requests sent, %0d range sums checked", requests_sent, sums_checked);
		$display("tb: loads, range roots with settled blocks, reversed ranges, stalls covered");
		if (fails == 0 && pending_sums.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#400ms;
		$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/risq_pkg.sv
sv/risq_front.sv
sv/risq_isqrt.sv
sv/risq_back.sv
sv/range_isqrt_range_sum_store.sv
tb/tb.sv
